[rtl/gzs_pkg.sv]
`timescale 1ns / 1ps

package gzs_pkg;

    // file length register and byte position width
    localparam int unsigned LEN_BITS = 32;
    localparam int unsigned CMP_BITS = LEN_BITS + 2;

    // output queue
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] MAGIC_0   = 8'h1f;
    localparam logic [7:0] MAGIC_1   = 8'h8b;
    localparam logic [7:0] METHOD_DF = 8'd8;
    localparam int unsigned MIN_FILE_LEN = 18;
    localparam int unsigned BLK_MARGIN   = 13;

    // parse phases
    localparam logic [3:0] PH_MAGIC   = 4'd0;
    localparam logic [3:0] PH_FLAGS   = 4'd1;
    localparam logic [3:0] PH_FIXED   = 4'd2;
    localparam logic [3:0] PH_XLEN_LO = 4'd3;
    localparam logic [3:0] PH_XLEN_HI = 4'd4;
    localparam logic [3:0] PH_EXTRA   = 4'd5;
    localparam logic [3:0] PH_NAME    = 4'd6;
    localparam logic [3:0] PH_COMMENT = 4'd7;
    localparam logic [3:0] PH_HCRC    = 4'd8;
    localparam logic [3:0] PH_BLOCK   = 4'd9;
    localparam logic [3:0] PH_LEN_LO  = 4'd10;
    localparam logic [3:0] PH_LEN_HI  = 4'd11;
    localparam logic [3:0] PH_NLEN    = 4'd12;
    localparam logic [3:0] PH_PAYLOAD = 4'd13;
    localparam logic [3:0] PH_DONE    = 4'd14;

    // status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_GZIP    = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
    localparam logic [1:0] ST_TRUNCATED   = 2'd3;

    // item kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // option bits: [0] header crc, [1] extra, [2] name, [3] comment
    localparam int unsigned OPT_HCRC    = 0;
    localparam int unsigned OPT_EXTRA   = 1;
    localparam int unsigned OPT_NAME    = 2;
    localparam int unsigned OPT_COMMENT = 3;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] payload_byte;
        logic [1:0] status;
    } t_out_word;

    typedef struct packed {
        logic [3:0] phase;
        logic [3:0] opt;
        logic       load_skip2;
    } t_hdr_next;

endpackage

[rtl/gzs_if.sv]
`timescale 1ns / 1ps

interface gzs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface gzs_out_if;
    logic       valid;
    logic       ready;
    logic       item_kind;
    logic [7:0] payload_byte;
    logic [1:0] status;

    modport source (output valid, output item_kind, output payload_byte, output status,
                    input ready);
    modport sink   (input valid, input item_kind, input payload_byte, input status,
                    output ready);
endinterface

[rtl/gzip_stored_deframer.sv]
// Channel   Dir  Word                                  Handshake
// i_in      in   data_byte[7:0]                        valid/ready
// o_out     out  item_kind, payload_byte[7:0],         valid/ready
//                status[1:0]
// i_cfg_*   in   stream_length[31:0]                   write enable, no wait
//
// One byte per clock: each byte is parsed in the cycle it is taken, against
// the parse registers, and its result words go into a 4-word output queue.
// A byte yields at most two words (payload + end-of-file status); the input
// is ready whenever the queue has two free slots, so the rate is set by the
// queue drain of one word per cycle. i_rst_n is synchronous, active low, and
// clears the parser, the queue and sets stream_length to 18.
`timescale 1ns / 1ps

module gzip_stored_deframer
    import gzs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [LEN_BITS-1:0] i_cfg_wr_data,
    gzs_in_if.sink              i_in,
    gzs_out_if.source           o_out
);

    // ------------------------------------------------------------------
    // parser state
    // ------------------------------------------------------------------
    logic [LEN_BITS-1:0] r_len, r_pos, n_pos;
    logic [3:0]          r_phase, n_phase;
    logic [3:0]          r_opt, n_opt;
    logic [16:0]         r_skip, n_skip;
    logic [7:0]          r_xlo, n_xlo;
    logic [15:0]         r_bbl, n_bbl;
    logic                r_final, n_final;
    logic [1:0]          r_err, n_err;

    // output queue
    t_out_word           r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [FIFO_CW-1:0]  r_count;

    logic                take, pop;
    logic                push_pay, push_stat;
    logic [7:0]          b;
    logic                at_end;
    logic                blk_late;
    logic                len_past;
    logic [15:0]         len_full;
    logic [16:0]         skip_dec;
    logic [7:0]          magic_want;

    // Header option sequencing: extra, name, comment, then header CRC.
    function automatic t_hdr_next hdr_next(input logic [3:0] opt);
        t_hdr_next r;
        r.opt        = opt;
        r.load_skip2 = 1'b0;
        if (opt[OPT_EXTRA]) begin
            r.opt[OPT_EXTRA] = 1'b0;
            r.phase          = PH_XLEN_LO;
        end else if (opt[OPT_NAME]) begin
            r.opt[OPT_NAME] = 1'b0;
            r.phase         = PH_NAME;
        end else if (opt[OPT_COMMENT]) begin
            r.opt[OPT_COMMENT] = 1'b0;
            r.phase            = PH_COMMENT;
        end else if (opt[OPT_HCRC]) begin
            r.opt[OPT_HCRC] = 1'b0;
            r.load_skip2    = 1'b1;
            r.phase         = PH_HCRC;
        end else begin
            r.phase = PH_BLOCK;
        end
        return r;
    endfunction

    assign i_in.ready = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign take       = i_in.valid & i_in.ready;
    assign pop        = o_out.valid & o_out.ready;
    assign b          = i_in.data_byte;

    // end of file: this byte is the last one (or the length was lowered)
    assign at_end   = (CMP_BITS'(r_pos) + CMP_BITS'(1)) >= CMP_BITS'(r_len);
    // a block header needs at least 13 bytes left from it
    assign blk_late = (CMP_BITS'(r_pos) + CMP_BITS'(BLK_MARGIN)) > CMP_BITS'(r_len);
    assign len_full = {b, r_bbl[7:0]};
    // LEN high byte, NLEN (2) and the payload must fit in the file
    assign len_past = (CMP_BITS'(r_pos) + CMP_BITS'(3) + CMP_BITS'(len_full))
                      > CMP_BITS'(r_len);
    assign skip_dec = (r_skip != '0) ? (r_skip - 17'd1) : r_skip;

    always_comb begin
        if (r_pos == '0) begin
            magic_want = MAGIC_0;
        end else if (r_pos == LEN_BITS'(1)) begin
            magic_want = MAGIC_1;
        end else begin
            magic_want = METHOD_DF;
        end
    end

    always_comb begin
        t_hdr_next hn;
        hn        = hdr_next(r_opt);
        n_phase   = r_phase;
        n_opt     = r_opt;
        n_skip    = r_skip;
        n_xlo     = r_xlo;
        n_bbl     = r_bbl;
        n_final   = r_final;
        n_err     = r_err;
        push_pay  = 1'b0;

        unique case (r_phase)
            PH_MAGIC: begin
                if ((r_pos == '0 && r_len < LEN_BITS'(MIN_FILE_LEN)) || b != magic_want) begin
                    n_err   = ST_NOT_GZIP;
                    n_phase = PH_DONE;
                end else if (r_pos >= LEN_BITS'(2)) begin
                    n_phase = PH_FLAGS;
                end
            end
            PH_FLAGS: begin
                n_opt   = b[4:1];
                n_skip  = 17'd6;
                n_phase = PH_FIXED;
            end
            PH_FIXED, PH_EXTRA, PH_HCRC: begin
                n_skip = skip_dec;
                if (skip_dec == '0) begin
                    if (r_phase == PH_HCRC) begin
                        n_phase = PH_BLOCK;
                    end else begin
                        n_phase = hn.phase;
                        n_opt   = hn.opt;
                        if (hn.load_skip2) begin
                            n_skip = 17'd2;
                        end
                    end
                end
            end
            PH_XLEN_LO: begin
                n_xlo   = b;
                n_phase = PH_XLEN_HI;
            end
            PH_XLEN_HI: begin
                // high byte taken as unsigned
                n_skip = {1'b0, b, r_xlo};
                if ({b, r_xlo} == 16'd0) begin
                    n_phase = hn.phase;
                    n_opt   = hn.opt;
                    if (hn.load_skip2) begin
                        n_skip = 17'd2;
                    end
                end else begin
                    n_phase = PH_EXTRA;
                end
            end
            PH_NAME, PH_COMMENT: begin
                if (b == 8'd0) begin
                    n_phase = hn.phase;
                    n_opt   = hn.opt;
                    if (hn.load_skip2) begin
                        n_skip = 17'd2;
                    end
                end
            end
            PH_BLOCK: begin
                if (blk_late) begin
                    n_phase = PH_DONE;
                end else if (b[2:1] != 2'd0) begin
                    n_err   = ST_UNSUPPORTED;
                    n_phase = PH_DONE;
                end else begin
                    n_final = b[0];
                    n_phase = PH_LEN_LO;
                end
            end
            PH_LEN_LO: begin
                n_bbl   = {8'd0, b};
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_bbl = len_full;
                if (len_past) begin
                    n_err   = ST_TRUNCATED;
                    n_phase = PH_DONE;
                end else begin
                    n_skip  = 17'd2;
                    n_phase = PH_NLEN;
                end
            end
            PH_NLEN: begin
                n_skip = skip_dec;
                if (skip_dec == '0) begin
                    if (r_bbl != '0) begin
                        n_phase = PH_PAYLOAD;
                    end else begin
                        n_phase = r_final ? PH_DONE : PH_BLOCK;
                    end
                end
            end
            PH_PAYLOAD: begin
                push_pay = 1'b1;
                if (r_bbl != '0) begin
                    n_bbl = r_bbl - 16'd1;
                end
                if (r_bbl <= 16'd1) begin
                    n_phase = r_final ? PH_DONE : PH_BLOCK;
                end
            end
            default: begin
                // done: bytes absorbed
            end
        endcase

        push_stat = at_end;
        n_pos     = r_pos + LEN_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_BITS'(MIN_FILE_LEN);
        end else if (i_cfg_wr_en) begin
            r_len <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (take && at_end)) begin
            r_pos   <= '0;
            r_phase <= PH_MAGIC;
            r_opt   <= '0;
            r_skip  <= '0;
            r_xlo   <= '0;
            r_bbl   <= '0;
            r_final <= 1'b0;
            r_err   <= ST_OK;
        end else if (take) begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_opt   <= n_opt;
            r_skip  <= n_skip;
            r_xlo   <= n_xlo;
            r_bbl   <= n_bbl;
            r_final <= n_final;
            r_err   <= n_err;
        end
    end

    // ------------------------------------------------------------------
    // output queue: up to two words in, one word out per cycle
    // ------------------------------------------------------------------
    t_out_word pay_word, stat_word;
    logic [1:0] push_cnt;

    assign pay_word  = '{item_kind: KIND_PAYLOAD, payload_byte: b, status: ST_OK};
    assign stat_word = '{item_kind: KIND_STATUS, payload_byte: 8'd0, status: n_err};
    assign push_cnt  = take ? ({1'b0, push_pay} + {1'b0, push_stat}) : 2'd0;

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (push_pay) begin
                r_mem[r_wr_ptr] <= pay_word;
                if (push_stat) begin
                    r_mem[r_wr_ptr + FIFO_AW'(1)] <= stat_word;
                end
            end else if (push_stat) begin
                r_mem[r_wr_ptr] <= stat_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(push_cnt);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= r_count + FIFO_CW'(push_cnt) - FIFO_CW'(pop);
        end
    end

    assign o_out.valid        = (r_count != '0);
    assign o_out.item_kind    = r_mem[r_rd_ptr].item_kind;
    assign o_out.payload_byte = r_mem[r_rd_ptr].payload_byte;
    assign o_out.status       = r_mem[r_rd_ptr].status;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("output queue overflow");

    a_eof_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && at_end) |=> (r_pos == '0 && r_phase == PH_MAGIC && r_err == ST_OK))
        else $error("parser not cleared after end of file");

    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_bbl != '0))
        else $error("payload phase with no bytes left");

    a_payload_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.item_kind == KIND_PAYLOAD) |-> (o_out.status == ST_OK))
        else $error("payload word carries a status");

endmodule
